/* hdl/polynomial_prefix_hash_table_defines.svh */
// ----------------------------------------------------------------------------
// polynomial prefix hash table assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_PREFIX_HASH_TABLE_DEFINES_SVH
`define POLYNOMIAL_PREFIX_HASH_TABLE_DEFINES_SVH

// assertion held off during reset
`define PPHT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion checked in every cycle, reset included
`define PPHT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/ppht_pkg.sv */
// ----------------------------------------------------------------------------
// ppht_pkg
// constants, codes and sequencer states of the polynomial prefix hash table
// ----------------------------------------------------------------------------
package ppht_pkg;

   localparam int MAX_LEN   = 1024;
   localparam int ALPHABET  = 256;
   localparam int HASH_W    = 30;
   localparam int LEN_W     = 11;
   localparam int SYM_W     = 8;
   localparam int CNT_W     = 5;
   localparam int MUL_STEPS = HASH_W;

   localparam logic [HASH_W-1:0] MODULUS          = 30'd1000000007;
   localparam logic [HASH_W-1:0] BASE_FIRST       = 30'd256;
   localparam logic [HASH_W-1:0] SECOND_BASE_INIT = 30'd257;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_QRD0,
      S_QRD1,
      S_QRD2,
      S_LOAD,
      S_MUL,
      S_FINISH,
      S_OUT
   } state_type;

endpackage

/* hdl/polynomial_prefix_hash_table.sv */
// append: four 30-step modular products on one shared unit
// query: three store reads, two modular products, one subtract
// clear, refused or unknown item: no modular products; one item in flight at a time
// results sit in an output register, so the next item is taken while one waits
// synchronous active-high reset; entry zero of every store is supplied by logic
// ----------------------------------------------------------------------------
// polynomial_prefix_hash_table
// prefix hashes at two bases mod a prime, with a bit-serial modular multiplier
// ----------------------------------------------------------------------------
module polynomial_prefix_hash_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // op, symbol, first_pos, last_pos
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // hash_first, hash_second, hash_length, zero pad
   output logic        rsp_tuser,   // error
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [29:0] csr_data     // second_base
);

   localparam int HW = ppht_pkg::HASH_W;
   localparam int LW = ppht_pkg::LEN_W;

   logic [1:0]    req_op;
   logic [7:0]    req_symbol;
   logic [LW-1:0] req_first_pos;
   logic [LW-1:0] req_last_pos;

   assign req_op        = req_tdata[1:0];
   assign req_symbol    = req_tdata[9:2];
   assign req_first_pos = req_tdata[20:10];
   assign req_last_pos  = req_tdata[31:21];

   ppht_pkg::state_type state_ff, state_in;

   logic [HW-1:0] base_ff;
   logic [LW-1:0] len_ff, len_in;
   logic [HW-1:0] tail_pre1_ff, tail_pre1_in, tail_pre2_ff, tail_pre2_in;
   logic [HW-1:0] tail_pow1_ff, tail_pow1_in, tail_pow2_ff, tail_pow2_in;
   logic          is_query_ff, is_query_in;
   logic [1:0]    step_ff, step_in;
   logic [7:0]    sym_ff, sym_in;
   logic [LW-1:0] first_ff, first_in, last_ff, last_in;
   logic [HW-1:0] qlast1_ff, qlast1_in, qlast2_ff, qlast2_in;
   logic [HW-1:0] qfirst1_ff, qfirst1_in, qfirst2_ff, qfirst2_in;
   logic [HW-1:0] qpow1_ff, qpow1_in, qpow2_ff, qpow2_in;
   logic [HW-1:0] prod_ff [4];
   logic [HW-1:0] prod_in [4];

   logic [HW-1:0]                 mul_a_ff, mul_a_in, mul_b_ff, mul_b_in, mul_r_ff, mul_r_in;
   logic [ppht_pkg::CNT_W-1:0]    mul_cnt_ff, mul_cnt_in;

   logic [HW-1:0] res_h1_ff, res_h1_in, res_h2_ff, res_h2_in;
   logic [LW-1:0] res_len_ff, res_len_in;
   logic          res_err_ff, res_err_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [HW-1:0] rsp_h1_ff, rsp_h2_ff;
   logic [LW-1:0] rsp_len_ff;
   logic          rsp_err_ff;
   logic          rsp_load;

   // stores
   logic [HW-1:0] pre1_mem [ppht_pkg::MAX_LEN+1];
   logic [HW-1:0] pre2_mem [ppht_pkg::MAX_LEN+1];
   logic [HW-1:0] pow1_mem [ppht_pkg::MAX_LEN+1];
   logic [HW-1:0] pow2_mem [ppht_pkg::MAX_LEN+1];
   logic          mem_we;
   logic [LW-1:0] mem_wa, pre_ra, pow_ra;
   logic [HW-1:0] wr_pre1, wr_pre2;
   logic [HW-1:0] pre1_rd_ff, pre2_rd_ff, pow1_rd_ff, pow2_rd_ff;
   logic          pre_zero_ff, pow_zero_ff;

   logic [HW-1:0] base2;
   logic [HW:0]   t0, t1, t2, t3;
   logic [HW:0]   sum1, sum2, sub1, sub2;
   logic          accept;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ppht_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign base2      = (base_ff >= ppht_pkg::MODULUS) ? base_ff - ppht_pkg::MODULUS : base_ff;

   // one step of the shared modular multiplier, multiplier bits msb first
   always_comb begin
      t0 = {mul_r_ff, 1'b0};
      t1 = (t0 >= {1'b0, ppht_pkg::MODULUS}) ? t0 - {1'b0, ppht_pkg::MODULUS} : t0;
      t2 = t1 + (mul_b_ff[HW-1] ? {1'b0, mul_a_ff} : '0);
      t3 = (t2 >= {1'b0, ppht_pkg::MODULUS}) ? t2 - {1'b0, ppht_pkg::MODULUS} : t2;
   end

   always_comb begin
      sum1 = {1'b0, prod_ff[0]} + {{(HW+1-8){1'b0}}, sym_ff};
      sum2 = {1'b0, prod_ff[1]} + {{(HW+1-8){1'b0}}, sym_ff};
      if (sum1 >= {1'b0, ppht_pkg::MODULUS}) sum1 = sum1 - {1'b0, ppht_pkg::MODULUS};
      if (sum2 >= {1'b0, ppht_pkg::MODULUS}) sum2 = sum2 - {1'b0, ppht_pkg::MODULUS};
      sub1 = (qlast1_ff >= prod_ff[0]) ? {1'b0, qlast1_ff} - {1'b0, prod_ff[0]}
                                       : {1'b0, qlast1_ff} + {1'b0, ppht_pkg::MODULUS}
                                         - {1'b0, prod_ff[0]};
      sub2 = (qlast2_ff >= prod_ff[1]) ? {1'b0, qlast2_ff} - {1'b0, prod_ff[1]}
                                       : {1'b0, qlast2_ff} + {1'b0, ppht_pkg::MODULUS}
                                         - {1'b0, prod_ff[1]};
   end

   assign wr_pre1 = sum1[HW-1:0];
   assign wr_pre2 = sum2[HW-1:0];
   assign rsp_load = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      tail_pre1_in = tail_pre1_ff;
      tail_pre2_in = tail_pre2_ff;
      tail_pow1_in = tail_pow1_ff;
      tail_pow2_in = tail_pow2_ff;
      is_query_in  = is_query_ff;
      step_in      = step_ff;
      sym_in       = sym_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      qlast1_in    = qlast1_ff;
      qlast2_in    = qlast2_ff;
      qfirst1_in   = qfirst1_ff;
      qfirst2_in   = qfirst2_ff;
      qpow1_in     = qpow1_ff;
      qpow2_in     = qpow2_ff;
      prod_in      = prod_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      mul_r_in     = mul_r_ff;
      mul_cnt_in   = mul_cnt_ff;
      res_h1_in    = res_h1_ff;
      res_h2_in    = res_h2_ff;
      res_len_in   = res_len_ff;
      res_err_in   = res_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_we       = 1'b0;
      mem_wa       = len_ff + LW'(1);
      pre_ra       = last_ff;
      pow_ra       = last_ff - first_ff;

      unique case (state_ff)
         ppht_pkg::S_IDLE: begin
            if (accept) begin
               res_h1_in  = '0;
               res_h2_in  = '0;
               res_len_in = '0;
               res_err_in = 1'b1;
               state_in   = ppht_pkg::S_OUT;
               unique case (req_op)
                  ppht_pkg::OP_APPEND: begin
                     if (len_ff == LW'(ppht_pkg::MAX_LEN) ||
                         {1'b0, req_symbol} >= 9'(ppht_pkg::ALPHABET)) begin
                        res_h1_in  = tail_pre1_ff;
                        res_h2_in  = tail_pre2_ff;
                        res_len_in = len_ff;
                     end else begin
                        sym_in      = req_symbol;
                        is_query_in = 1'b0;
                        step_in     = '0;
                        state_in    = ppht_pkg::S_LOAD;
                     end
                  end
                  ppht_pkg::OP_QUERY: begin
                     if (!(req_first_pos > req_last_pos || req_last_pos > len_ff)) begin
                        first_in    = req_first_pos;
                        last_in     = req_last_pos;
                        is_query_in = 1'b1;
                        step_in     = '0;
                        state_in    = ppht_pkg::S_QRD0;
                     end
                  end
                  ppht_pkg::OP_CLEAR: begin
                     len_in       = '0;
                     tail_pre1_in = '0;
                     tail_pre2_in = '0;
                     tail_pow1_in = HW'(1);
                     tail_pow2_in = HW'(1);
                     res_err_in   = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ppht_pkg::S_QRD0: begin
            state_in = ppht_pkg::S_QRD1;
         end
         ppht_pkg::S_QRD1: begin
            qlast1_in = pre_zero_ff ? '0 : pre1_rd_ff;
            qlast2_in = pre_zero_ff ? '0 : pre2_rd_ff;
            qpow1_in  = pow_zero_ff ? HW'(1) : pow1_rd_ff;
            qpow2_in  = pow_zero_ff ? HW'(1) : pow2_rd_ff;
            pre_ra    = first_ff;
            state_in  = ppht_pkg::S_QRD2;
         end
         ppht_pkg::S_QRD2: begin
            qfirst1_in = pre_zero_ff ? '0 : pre1_rd_ff;
            qfirst2_in = pre_zero_ff ? '0 : pre2_rd_ff;
            state_in   = ppht_pkg::S_LOAD;
         end
         ppht_pkg::S_LOAD: begin
            mul_r_in   = '0;
            mul_cnt_in = '0;
            if (is_query_ff) begin
               mul_a_in = step_ff[0] ? qfirst2_ff : qfirst1_ff;
               mul_b_in = step_ff[0] ? qpow2_ff : qpow1_ff;
            end else begin
               unique case (step_ff)
                  2'd0:    mul_a_in = tail_pre1_ff;
                  2'd1:    mul_a_in = tail_pre2_ff;
                  2'd2:    mul_a_in = tail_pow1_ff;
                  default: mul_a_in = tail_pow2_ff;
               endcase
               mul_b_in = step_ff[0] ? base2 : ppht_pkg::BASE_FIRST;
            end
            state_in = ppht_pkg::S_MUL;
         end
         ppht_pkg::S_MUL: begin
            mul_r_in   = t3[HW-1:0];
            mul_b_in   = {mul_b_ff[HW-2:0], 1'b0};
            mul_cnt_in = mul_cnt_ff + ppht_pkg::CNT_W'(1);
            if (mul_cnt_ff == ppht_pkg::CNT_W'(ppht_pkg::MUL_STEPS - 1)) begin
               prod_in[step_ff] = t3[HW-1:0];
               step_in          = step_ff + 2'd1;
               if ((is_query_ff && step_ff == 2'd1) || (!is_query_ff && step_ff == 2'd3))
                  state_in = ppht_pkg::S_FINISH;
               else
                  state_in = ppht_pkg::S_LOAD;
            end
         end
         ppht_pkg::S_FINISH: begin
            res_err_in = 1'b0;
            if (is_query_ff) begin
               res_h1_in  = sub1[HW-1:0];
               res_h2_in  = sub2[HW-1:0];
               res_len_in = last_ff - first_ff;
            end else begin
               mem_we       = 1'b1;
               tail_pre1_in = wr_pre1;
               tail_pre2_in = wr_pre2;
               tail_pow1_in = prod_ff[2];
               tail_pow2_in = prod_ff[3];
               len_in       = len_ff + LW'(1);
               res_h1_in    = wr_pre1;
               res_h2_in    = wr_pre2;
               res_len_in   = len_ff + LW'(1);
            end
            state_in = ppht_pkg::S_OUT;
         end
         ppht_pkg::S_OUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ppht_pkg::S_IDLE;
            end
         end
         default: state_in = ppht_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pre1_mem[mem_wa] <= wr_pre1;
         pre2_mem[mem_wa] <= wr_pre2;
         pow1_mem[mem_wa] <= prod_ff[2];
         pow2_mem[mem_wa] <= prod_ff[3];
      end
      pre1_rd_ff  <= pre1_mem[pre_ra];
      pre2_rd_ff  <= pre2_mem[pre_ra];
      pow1_rd_ff  <= pow1_mem[pow_ra];
      pow2_rd_ff  <= pow2_mem[pow_ra];
      pre_zero_ff <= (pre_ra == '0);
      pow_zero_ff <= (pow_ra == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppht_pkg::S_IDLE;
         base_ff      <= ppht_pkg::SECOND_BASE_INIT;
         len_ff       <= '0;
         tail_pre1_ff <= '0;
         tail_pre2_ff <= '0;
         tail_pow1_ff <= HW'(1);
         tail_pow2_ff <= HW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_valid && csr_ready) base_ff <= csr_data;
         len_ff       <= len_in;
         tail_pre1_ff <= tail_pre1_in;
         tail_pre2_ff <= tail_pre2_in;
         tail_pow1_ff <= tail_pow1_in;
         tail_pow2_ff <= tail_pow2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_query_ff <= is_query_in;
      step_ff     <= step_in;
      sym_ff      <= sym_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      qlast1_ff   <= qlast1_in;
      qlast2_ff   <= qlast2_in;
      qfirst1_ff  <= qfirst1_in;
      qfirst2_ff  <= qfirst2_in;
      qpow1_ff    <= qpow1_in;
      qpow2_ff    <= qpow2_in;
      prod_ff     <= prod_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      mul_r_ff    <= mul_r_in;
      mul_cnt_ff  <= mul_cnt_in;
      res_h1_ff   <= res_h1_in;
      res_h2_ff   <= res_h2_in;
      res_len_ff  <= res_len_in;
      res_err_ff  <= res_err_in;
      if (state_ff == ppht_pkg::S_OUT && rsp_load) begin
         rsp_h1_ff  <= res_h1_ff;
         rsp_h2_ff  <= res_h2_ff;
         rsp_len_ff <= res_len_ff;
         rsp_err_ff <= res_err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_len_ff, rsp_h2_ff, rsp_h1_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

/* hdl/ppht_checker.sv */
// ----------------------------------------------------------------------------
// ppht_checker
// port-level checks of the polynomial prefix hash table
// ----------------------------------------------------------------------------
`include "polynomial_prefix_hash_table_defines.svh"

module ppht_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   `PPHT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result after reset")
   `PPHT_ASSERT(a_busy_after_item, clock, reset, req_tvalid && req_tready |=> !req_tready, "ready right after item")
   `PPHT_ASSERT(a_hash_reduced, clock, reset, rsp_tvalid |-> (rsp_tdata[29:0] < ppht_pkg::MODULUS) && (rsp_tdata[59:30] < ppht_pkg::MODULUS), "hash not reduced")
   `PPHT_ASSERT(a_length_bound, clock, reset, rsp_tvalid |-> rsp_tdata[70:60] <= 11'(ppht_pkg::MAX_LEN), "length too large")
   `PPHT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

endmodule

bind polynomial_prefix_hash_table ppht_checker u_ppht_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
